FILE: hw/rtl/dual_channel_windowed_rms_meter_assert.svh
// Assertion macros for the dual-channel RMS meter (empty in synthesis).
`ifndef DUAL_CHANNEL_WINDOWED_RMS_METER_ASSERT_SVH
`define DUAL_CHANNEL_WINDOWED_RMS_METER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off while rst_n is low
`define RMSM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rms meter check failed");
// next-cycle implication
`define RMSM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rms meter check failed");
`else
`define RMSM_ASSERT_IMP(lbl, ante, cons)
`define RMSM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/rmsm_pkg.sv
// Shared constants and register codes of the dual-channel RMS meter.
`default_nettype none

package rmsm_pkg;

  // default widths
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int WINDOW_BITS_DEF = 12;

  // fixed field widths
  localparam int GAIN_BITS = 20;
  localparam int GAIN_FRAC = 16;
  localparam int RMS_BITS  = 16;

  // register reset values
  localparam int WINDOW_LEN_RST = 123;
  localparam int GAIN_CUR_RST   = 2000;
  localparam int GAIN_VOL_RST   = 121484;

  // configuration register map
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OFFSET_CUR = 3'd0,
    REG_OFFSET_VOL = 3'd1,
    REG_WINDOW_LEN = 3'd2,
    REG_GAIN_CUR   = 3'd3,
    REG_GAIN_VOL   = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rmsm_if.sv
// Valid/ready channel interfaces for sample pairs and RMS results.
`default_nettype none

// sample pair channel
interface rmsm_in_if import rmsm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_sample;
  logic [SAMPLE_BITS-1:0] voltage_sample;

  modport source (output valid, output current_sample, output voltage_sample, input ready);
  modport sink   (input valid, input current_sample, input voltage_sample, output ready);
endinterface

// RMS result channel
interface rmsm_out_if import rmsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RMS_BITS-1:0] rms_current;
  logic [RMS_BITS-1:0] rms_voltage;

  modport source (output valid, output rms_current, output rms_voltage, input ready);
  modport sink   (input valid, input rms_current, input rms_voltage, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dual_channel_windowed_rms_meter.sv
// Dual-channel windowed true-RMS meter: square-accumulate, divide, root, scale.
//
//   port    dir  word                               handshake
//   in_if   in   current_sample, voltage_sample     valid/ready
//   out_if  out  rms_current, rms_voltage           valid/ready
//   cfg_*   in   register index, write data         cfg_we, no stall
//
// A sample word that does not close a window is accepted, then passes three
// multiply/accumulate steps through the one shared multiplier.
// For a closing word, each channel in turn runs a restoring divide and a
// bit-pair square root that share one subtractor, one bit per cycle, and is
// then scaled by the shared multiplier and saturated. The result holds in the
// output register until taken; no new word is taken meanwhile. Synchronous
// reset clears sums, count and state; config registers take their defaults.
`default_nettype none
`include "dual_channel_windowed_rms_meter_assert.svh"

module dual_channel_windowed_rms_meter import rmsm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int WINDOW_BITS = WINDOW_BITS_DEF,
  localparam int CFG_W = (GAIN_BITS > SAMPLE_BITS) ?
                         ((GAIN_BITS > WINDOW_BITS) ? GAIN_BITS : WINDOW_BITS) :
                         ((SAMPLE_BITS > WINDOW_BITS) ? SAMPLE_BITS : WINDOW_BITS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_W-1:0]        cfg_wdata,
  rmsm_in_if.sink                 in_if,
  rmsm_out_if.source              out_if
);

  localparam int ACC_BITS = 2 * SAMPLE_BITS + WINDOW_BITS;
  localparam int SQ_BITS  = 2 * SAMPLE_BITS;
  localparam int SQ_STEPS = (ACC_BITS + 1) / 2;
  localparam int WORK_W   = 2 * SQ_STEPS;
  localparam int MA       = SQ_STEPS;   // covers root and sample magnitude
  localparam int MB       = GAIN_BITS;  // covers gain and sample magnitude
  localparam int PW       = MA + MB;
  localparam int SUB_W    = (WINDOW_BITS + 1 > SQ_STEPS + 3) ? WINDOW_BITS + 1 : SQ_STEPS + 3;
  localparam int REM_W    = (WINDOW_BITS > SQ_STEPS + 1) ? WINDOW_BITS : SQ_STEPS + 1;
  localparam int STEP_W   = $clog2(ACC_BITS);

  localparam logic [SAMPLE_BITS-1:0] OFFSET_RST = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [PW-1:0]          SAT_LIM    = PW'((1 << RMS_BITS) - 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SQ_CUR  = 9'b000000010,
    ST_SQ_VOL  = 9'b000000100,
    ST_ACC_VOL = 9'b000001000,
    ST_DIV     = 9'b000010000,
    ST_SQRT    = 9'b000100000,
    ST_MUL     = 9'b001000000,
    ST_SAT     = 9'b010000000,
    ST_OUT     = 9'b100000000
  } state_t;

  // configuration registers
  logic [SAMPLE_BITS-1:0] offset_cur_r, offset_vol_r;
  logic [WINDOW_BITS-1:0] window_len_r;
  logic [GAIN_BITS-1:0]   gain_cur_r, gain_vol_r;

  // control state
  state_t                 state_r, state_nxt;
  logic                   ch_r, ch_nxt;
  logic [WINDOW_BITS-1:0] count_r, count_nxt;
  logic [ACC_BITS-1:0]    cur_sum_r, cur_sum_nxt;
  logic [ACC_BITS-1:0]    vol_sum_r, vol_sum_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  // datapath registers
  logic [SAMPLE_BITS-1:0] mag_cur_r, mag_cur_nxt;
  logic [SAMPLE_BITS-1:0] mag_vol_r, mag_vol_nxt;
  logic [WORK_W-1:0]      work_r, work_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [SQ_STEPS-1:0]    root_r, root_nxt;
  logic [PW-1:0]          prod_r;
  logic [RMS_BITS-1:0]    rms_cur_r, rms_cur_nxt;
  logic [RMS_BITS-1:0]    rms_vol_r, rms_vol_nxt;

  // shared units
  logic [MA-1:0]          mul_a;
  logic [MB-1:0]          mul_b;
  logic [PW-1:0]          mul_p;
  logic [SUB_W-1:0]       sub_a, sub_b;
  logic [SUB_W:0]         sub_d;
  logic                   sub_ge;

  logic [WINDOW_BITS-1:0] len;
  logic [WINDOW_BITS:0]   count_inc;
  logic                   win_close;
  logic                   in_acc;
  logic [PW-1:0]          scaled;
  logic [RMS_BITS-1:0]    sat_val;

  // a window length of zero acts as one
  assign len       = (window_len_r == '0) ? WINDOW_BITS'(1) : window_len_r;
  assign count_inc = {1'b0, count_r} + (WINDOW_BITS+1)'(1);
  assign win_close = count_inc >= {1'b0, len};
  assign in_acc    = in_if.valid && in_if.ready;

  // handshake and result word
  assign in_if.ready        = (state_r == ST_IDLE);
  assign out_if.valid       = (state_r == ST_OUT);
  assign out_if.rms_current = rms_cur_r;
  assign out_if.rms_voltage = rms_vol_r;

  // shared multiplier: squares, then root times gain
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ_CUR: begin
        mul_a = MA'(mag_cur_r);
        mul_b = MB'(mag_cur_r);
      end
      ST_SQ_VOL: begin
        mul_a = MA'(mag_vol_r);
        mul_b = MB'(mag_vol_r);
      end
      ST_MUL: begin
        mul_a = root_r;
        mul_b = ch_r ? gain_vol_r : gain_cur_r;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared subtractor: divide remainder step or root trial step
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_r)
      ST_DIV: begin
        sub_a = SUB_W'({rem_r[WINDOW_BITS-1:0], work_r[ACC_BITS-1]});
        sub_b = SUB_W'(len);
      end
      ST_SQRT: begin
        sub_a = SUB_W'({rem_r[SQ_STEPS:0], work_r[WORK_W-1 -: 2]});
        sub_b = SUB_W'({root_r, 2'b01});
      end
      default: begin
      end
    endcase
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_d[SUB_W];

  // truncate the Q16 product, saturate to the result width
  assign scaled  = prod_r >> GAIN_FRAC;
  assign sat_val = (scaled > SAT_LIM) ? {RMS_BITS{1'b1}} : scaled[RMS_BITS-1:0];

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    count_nxt   = count_r;
    cur_sum_nxt = cur_sum_r;
    vol_sum_nxt = vol_sum_r;
    step_nxt    = step_r;
    mag_cur_nxt = mag_cur_r;
    mag_vol_nxt = mag_vol_r;
    work_nxt    = work_r;
    rem_nxt     = rem_r;
    root_nxt    = root_r;
    rms_cur_nxt = rms_cur_r;
    rms_vol_nxt = rms_vol_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mag_cur_nxt = (in_if.current_sample >= offset_cur_r) ?
                        in_if.current_sample - offset_cur_r :
                        offset_cur_r - in_if.current_sample;
          mag_vol_nxt = (in_if.voltage_sample >= offset_vol_r) ?
                        in_if.voltage_sample - offset_vol_r :
                        offset_vol_r - in_if.voltage_sample;
          state_nxt   = ST_SQ_CUR;
        end
      end
      ST_SQ_CUR: begin
        state_nxt = ST_SQ_VOL;
      end
      ST_SQ_VOL: begin
        cur_sum_nxt = cur_sum_r + ACC_BITS'(prod_r[SQ_BITS-1:0]);
        state_nxt   = ST_ACC_VOL;
      end
      ST_ACC_VOL: begin
        vol_sum_nxt = vol_sum_r + ACC_BITS'(prod_r[SQ_BITS-1:0]);
        if (win_close) begin
          // start on the current channel
          ch_nxt    = 1'b0;
          work_nxt  = WORK_W'(cur_sum_r);
          rem_nxt   = '0;
          step_nxt  = STEP_W'(ACC_BITS - 1);
          state_nxt = ST_DIV;
        end else begin
          count_nxt = count_inc[WINDOW_BITS-1:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        // restoring divide, quotient shifts in at the bottom
        rem_nxt  = sub_ge ? REM_W'(sub_d[WINDOW_BITS-1:0]) : REM_W'(sub_a[WINDOW_BITS-1:0]);
        work_nxt = WORK_W'({work_r[ACC_BITS-2:0], sub_ge});
        if (step_r == '0) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = STEP_W'(SQ_STEPS - 1);
          state_nxt = ST_SQRT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_SQRT: begin
        // one root bit per cycle from the top bit pair
        rem_nxt  = sub_ge ? REM_W'(sub_d[SQ_STEPS:0]) : REM_W'(sub_a[SQ_STEPS:0]);
        root_nxt = {root_r[SQ_STEPS-2:0], sub_ge};
        work_nxt = {work_r[WORK_W-3:0], 2'b00};
        if (step_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_MUL: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!ch_r) begin
          rms_cur_nxt = sat_val;
          ch_nxt      = 1'b1;
          work_nxt    = WORK_W'(vol_sum_r);
          rem_nxt     = '0;
          step_nxt    = STEP_W'(ACC_BITS - 1);
          state_nxt   = ST_DIV;
        end else begin
          rms_vol_nxt = sat_val;
          cur_sum_nxt = '0;
          vol_sum_nxt = '0;
          count_nxt   = '0;
          state_nxt   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_if.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ch_r      <= 1'b0;
      count_r   <= '0;
      cur_sum_r <= '0;
      vol_sum_r <= '0;
      step_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ch_r      <= ch_nxt;
      count_r   <= count_nxt;
      cur_sum_r <= cur_sum_nxt;
      vol_sum_r <= vol_sum_nxt;
      step_r    <= step_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_cur_r <= mag_cur_nxt;
    mag_vol_r <= mag_vol_nxt;
    work_r    <= work_nxt;
    rem_r     <= rem_nxt;
    root_r    <= root_nxt;
    prod_r    <= mul_p;
    rms_cur_r <= rms_cur_nxt;
    rms_vol_r <= rms_vol_nxt;
  end

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_cur_r <= OFFSET_RST;
      offset_vol_r <= OFFSET_RST;
      window_len_r <= WINDOW_BITS'(WINDOW_LEN_RST);
      gain_cur_r   <= GAIN_BITS'(GAIN_CUR_RST);
      gain_vol_r   <= GAIN_BITS'(GAIN_VOL_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_OFFSET_CUR: offset_cur_r <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_OFFSET_VOL: offset_vol_r <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_WINDOW_LEN: window_len_r <= cfg_wdata[WINDOW_BITS-1:0];
        REG_GAIN_CUR:   gain_cur_r   <= cfg_wdata[GAIN_BITS-1:0];
        REG_GAIN_VOL:   gain_vol_r   <= cfg_wdata[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // checks
  `RMSM_ASSERT_IMP(a_out_sums_clear, out_if.valid, (cur_sum_r == '0 && vol_sum_r == '0 && count_r == '0))
  `RMSM_ASSERT_IMP(a_div_rem_below_len, (state_r == ST_DIV), (rem_r[WINDOW_BITS-1:0] < len))
  `RMSM_ASSERT_IMP(a_sqrt_rem_bound, (state_r == ST_SQRT), ({1'b0, rem_r[SQ_STEPS:0]} <= {1'b0, root_r, 1'b0}))
  `RMSM_ASSERT_NXT(a_out_taken_ready, (out_if.valid && out_if.ready), in_if.ready)

endmodule

`default_nettype wire
